### hw/rtl/brbo_pkg.sv
package brbo_pkg;

	// field widths of the request and result ports
	localparam int OP_W   = 2;
	localparam int DATA_W = 8;
	localparam int LEN_W  = 7;
	localparam int FILL_W = 11;
	localparam int CFG_W  = 4;

	// parameter defaults
	localparam int DEPTH_DEF   = 1024;
	localparam int MAX_RUN_DEF = 64;

	// capacity_log2 after reset
	localparam int CAP_LOG2_RST = 10;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_FORCE = 2'd1;
	localparam logic [OP_W-1:0] OP_GET   = 2'd2;

	// controller to datapath commands for the current cycle
	typedef struct packed {
		logic put;     // store a byte
		logic forced;  // put may drop the oldest byte
		logic read;    // read one byte from the ring
		logic empty;   // result with no byte and no change
		logic last;    // final result of this request
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [LEN_W-1:0] avail_len;  // bytes a get would return now
	} status_t;

endpackage

### hw/rtl/byte_ring_buffer_overwrite.sv
// Byte FIFO over a circular store with overwrite of the oldest byte. A request is
// taken at a rising edge with start high and busy low. op selects a plain put,
// a forced put, or a get of up to request_len bytes (at most MAX_RUN). Results
// appear in the cycle after the request and each is on the ports for one cycle,
// marked by done; the receiver cannot hold them off, so it must take every
// strobe. A put, an empty get or an unused op gives one result and a new request
// can follow in the very next cycle. A get of n bytes gives n results, one per
// cycle, since the store has a single port read once per cycle; busy stays high
// until the last byte is read. cfg_write loads capacity_log2 and empties
// the ring at once, with no clearing pass; write it only while no results are
// pending. A get never returns more bytes than the ring holds.
module byte_ring_buffer_overwrite #(
	parameter int DEPTH   = brbo_pkg::DEPTH_DEF,
	parameter int MAX_RUN = brbo_pkg::MAX_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [brbo_pkg::OP_W-1:0]    op,
	input  logic [brbo_pkg::DATA_W-1:0]  data_in,
	input  logic                         first_in,
	input  logic                         last_in,
	input  logic [brbo_pkg::LEN_W-1:0]   request_len,
	input  logic                         cfg_write,
	input  logic [brbo_pkg::CFG_W-1:0]   cfg_data,
	output logic                         done,
	output logic [brbo_pkg::DATA_W-1:0]  data_out,
	output logic                         byte_valid,
	output logic                         accepted,
	output logic                         overwrote,
	output logic                         last_out,
	output logic [brbo_pkg::FILL_W-1:0]  fill_level
);

	brbo_pkg::cmd_t    cmd;
	brbo_pkg::status_t status;

	// sequencer for puts and get runs
	brbo_ctrl #(
		.MAX_RUN (MAX_RUN)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// counters, byte store and result registers
	brbo_dp #(
		.DEPTH   (DEPTH),
		.MAX_RUN (MAX_RUN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_in     (data_in),
		.first_in    (first_in),
		.last_in     (last_in),
		.request_len (request_len),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.done        (done),
		.data_out    (data_out),
		.byte_valid  (byte_valid),
		.accepted    (accepted),
		.overwrote   (overwrote),
		.last_out    (last_out),
		.fill_level  (fill_level)
	);

endmodule

### hw/rtl/brbo_ctrl.sv
module brbo_ctrl #(
	parameter int MAX_RUN = brbo_pkg::MAX_RUN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [brbo_pkg::OP_W-1:0] op,
	input  brbo_pkg::status_t         status,
	output logic                      busy,
	output brbo_pkg::cmd_t            cmd
);

	localparam int RUN_W = $clog2(MAX_RUN + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t             state_q, state_nx;
	logic [RUN_W-1:0]   rem_q, rem_nx;
	logic [RUN_W-1:0]   avail_r;

	// run length never exceeds MAX_RUN
	assign avail_r = RUN_W'(status.avail_len);

	// command decode and next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		rem_nx   = rem_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op)
						brbo_pkg::OP_PUT, brbo_pkg::OP_FORCE: begin
							cmd.put    = 1'b1;
							cmd.forced = (op == brbo_pkg::OP_FORCE);
							cmd.last   = 1'b1;
						end
						brbo_pkg::OP_GET: begin
							if (avail_r == '0) begin
								cmd.empty = 1'b1;
								cmd.last  = 1'b1;
							end else begin
								cmd.read = 1'b1;
								cmd.last = (avail_r == RUN_W'(1));
								if (avail_r != RUN_W'(1)) begin
									state_nx = ST_RUN;
									rem_nx   = avail_r - RUN_W'(1);
								end
							end
						end
						default: begin
							cmd.empty = 1'b1;
							cmd.last  = 1'b1;
						end
					endcase
				end
			end
			ST_RUN: begin
				cmd.read = 1'b1;
				cmd.last = (rem_q == RUN_W'(1));
				rem_nx   = rem_q - RUN_W'(1);
				if (rem_q == RUN_W'(1)) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state and run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_nx;
			rem_q   <= rem_nx;
		end
	end

	assign busy = (state_q == ST_RUN);

`ifndef NO_ASSERTIONS
	// a run in progress always has bytes left to read
	a_run_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> rem_q != '0)
		else $error("run state with no bytes left");

	// at most one kind of step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.put, cmd.read, cmd.empty}))
		else $error("more than one step in a cycle");

	// the last byte of a run frees the block
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read && cmd.last |=> state_q == ST_IDLE)
		else $error("still busy after last byte");
`endif

endmodule

### hw/rtl/brbo_dp.sv
module brbo_dp #(
	parameter int DEPTH   = brbo_pkg::DEPTH_DEF,
	parameter int MAX_RUN = brbo_pkg::MAX_RUN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [brbo_pkg::DATA_W-1:0]  data_in,
	input  logic                         first_in,
	input  logic                         last_in,
	input  logic [brbo_pkg::LEN_W-1:0]   request_len,
	input  logic                         cfg_write,
	input  logic [brbo_pkg::CFG_W-1:0]   cfg_data,
	input  brbo_pkg::cmd_t               cmd,
	output brbo_pkg::status_t            status,
	output logic                         done,
	output logic [brbo_pkg::DATA_W-1:0]  data_out,
	output logic                         byte_valid,
	output logic                         accepted,
	output logic                         overwrote,
	output logic                         last_out,
	output logic [brbo_pkg::FILL_W-1:0]  fill_level
);

	// store holds the largest power of two not above DEPTH
	localparam int AW      = $clog2(DEPTH + 1) - 1;
	localparam int CW      = AW + 1;
	localparam int ENTRIES = 1 << AW;
	localparam int RST_L   = (brbo_pkg::CAP_LOG2_RST < 1) ? 1 :
		((brbo_pkg::CAP_LOG2_RST > AW) ? AW : brbo_pkg::CAP_LOG2_RST);
	localparam logic [CW-1:0] RST_CAP = CW'(1) << RST_L;
	localparam logic [CW-1:0] MAX_CAP = CW'(1) << AW;
	localparam logic [brbo_pkg::LEN_W-1:0] RUN_MAX = brbo_pkg::LEN_W'(MAX_RUN);

	logic [brbo_pkg::DATA_W-1:0] mem [ENTRIES];

	logic [CW-1:0] cap_q, wr_q, rd_q, seen_q;
	logic [CW-1:0] wr_nx, rd_nx, seen_nx;
	logic [CW-1:0] held, held_nx, mask, seen_base, cfg_cap;
	logic [AW-1:0] waddr, raddr;
	logic          room, seen_room, acc_c, ovw_c, step;
	logic [brbo_pkg::LEN_W-1:0] req_c;

	logic                        done_q, bv_q, acc_q, ovw_q, last_q;
	logic [brbo_pkg::DATA_W-1:0] rdata_q;
	logic [brbo_pkg::FILL_W-1:0] fill_q;

	// ring occupancy and addresses
	assign held  = wr_q - rd_q;
	assign mask  = cap_q - CW'(1);
	assign waddr = wr_q[AW-1:0] & mask[AW-1:0];
	assign raddr = rd_q[AW-1:0] & mask[AW-1:0];

	// bytes a get would return
	always_comb begin
		req_c = (request_len > RUN_MAX) ? RUN_MAX : request_len;
		if (32'(held) < 32'(req_c)) begin
			status.avail_len = brbo_pkg::LEN_W'(held);
		end else begin
			status.avail_len = req_c;
		end
	end

	// put decision
	assign seen_base = first_in ? '0 : seen_q;
	assign room      = (held < cap_q);
	assign seen_room = (seen_base < cap_q);
	assign acc_c     = cmd.forced ? seen_room : room;
	assign ovw_c     = cmd.forced & seen_room & ~room;

	// next counter values
	always_comb begin
		wr_nx   = wr_q;
		rd_nx   = rd_q;
		seen_nx = seen_q;
		if (cmd.put) begin
			if (acc_c) begin
				wr_nx = wr_q + CW'(1);
			end
			if (ovw_c) begin
				rd_nx = rd_q + CW'(1);
			end
			if (last_in) begin
				seen_nx = '0;
			end else if (seen_room) begin
				seen_nx = seen_base + CW'(1);
			end else begin
				seen_nx = seen_base;
			end
		end
		if (cmd.read) begin
			rd_nx = rd_q + CW'(1);
		end
	end

	assign held_nx = wr_nx - rd_nx;

	// capacity from a register write, clamped to the store
	always_comb begin
		if (cfg_data == '0) begin
			cfg_cap = CW'(2);
		end else if (int'(cfg_data) > AW) begin
			cfg_cap = MAX_CAP;
		end else begin
			cfg_cap = CW'(1) << cfg_data;
		end
	end

	// capacity and counters; a capacity write empties the ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= RST_CAP;
			wr_q   <= '0;
			rd_q   <= '0;
			seen_q <= '0;
		end else if (cfg_write) begin
			cap_q  <= cfg_cap;
			wr_q   <= '0;
			rd_q   <= '0;
			seen_q <= '0;
		end else begin
			wr_q   <= wr_nx;
			rd_q   <= rd_nx;
			seen_q <= seen_nx;
		end
	end

	// byte store, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (cmd.put && acc_c) begin
			mem[waddr] <= data_in;
		end
		if (cmd.read) begin
			rdata_q <= mem[raddr];
		end
	end

	assign step = cmd.put | cmd.read | cmd.empty;

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= step;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (step) begin
			bv_q   <= cmd.read;
			acc_q  <= cmd.put & acc_c;
			ovw_q  <= cmd.put & ovw_c;
			last_q <= cmd.last;
			fill_q <= brbo_pkg::FILL_W'(held_nx);
		end
	end

	assign done       = done_q;
	assign data_out   = bv_q ? rdata_q : '0;
	assign byte_valid = bv_q;
	assign accepted   = acc_q;
	assign overwrote  = ovw_q;
	assign last_out   = last_q;
	assign fill_level = fill_q;

`ifndef NO_ASSERTIONS
	// buffer byte count saturates at the capacity
	a_seen_cap: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= cap_q)
		else $error("buffer byte count above capacity");

	// an overwrite leaves the ring full
	a_ovw_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put && ovw_c && !cfg_write |=> (wr_q - rd_q) == cap_q)
		else $error("ring not full after overwrite");

	// an overwrite result always reports the byte stored
	a_ovw_acc: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && ovw_q |-> acc_q && !bv_q)
		else $error("overwrite without stored byte");
`endif

endmodule
